// File: src/hps_pkg.sv
// shared types and constants for the hash partition scatter block
package hps_pkg;

  localparam int KEY_W     = 64;
  localparam int KEY_IDX_W = 6;
  localparam int PAY_W     = 64;
  localparam int CNT_REG_W = 11;
  localparam int CAP_REG_W = 21;
  localparam int PART_W    = 10;
  localparam int SLOT_W    = 20;
  localparam int ADDR_W    = 30;
  localparam int FILL_W    = 21;
  localparam int PROD_W    = CNT_REG_W + CAP_REG_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = CAP_REG_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_CAPACITY = 1'd1;

  localparam logic CMD_PARTITION = 1'b0;
  localparam logic CMD_CLEAR     = 1'b1;

  // effective configuration after clamping
  typedef struct packed {
    logic [CNT_REG_W-1:0] count;
    logic [CAP_REG_W-1:0] capacity;
  } hps_cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic                 cmd;
    logic [CNT_REG_W-1:0] part;
    logic [KEY_W-1:0]     key;
    logic [PAY_W-1:0]     payload;
  } q_item_t;

endpackage

// File: src/hps_if.sv
// tuple and result channel interfaces
interface hps_in_if import hps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output cmd, output key, output payload, input ready);
  modport sink (input valid, input cmd, input key, input payload, output ready);
endinterface

interface hps_out_if import hps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PART_W-1:0] partition;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] address;
  logic [KEY_W-1:0]  key_out;
  logic [PAY_W-1:0]  payload_out;
  logic              overflow;

  modport source (output valid, output partition, output slot, output address,
                  output key_out, output payload_out, output overflow, input ready);
  modport sink (input valid, input partition, input slot, input address,
                input key_out, input payload_out, input overflow, output ready);
endinterface

// File: src/hps_front.sv
// front end: accepts tuples and computes key mod partition count bit-serially
module hps_front import hps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  hps_cfg_t   cfg,
  hps_in_if.sink     tuple_in,
  output logic       push_valid,
  input  logic       push_ready,
  output q_item_t    push_item
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} f_state_t;

  f_state_t             state;
  q_item_t              item;
  logic [KEY_IDX_W-1:0] bit_idx;
  logic [CNT_REG_W:0]   trial;
  logic [CNT_REG_W-1:0] rem_next;

  // one restoring step: shift in the next key bit, subtract the divisor if it fits
  always_comb begin
    trial = {item.part, item.key[bit_idx]};
    if (trial >= {1'b0, cfg.count}) begin
      rem_next = CNT_REG_W'(trial - {1'b0, cfg.count});
    end else begin
      rem_next = trial[CNT_REG_W-1:0];
    end
  end

  assign tuple_in.ready = (state == F_IDLE);
  assign push_valid     = (state == F_PUSH);
  assign push_item      = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      bit_idx <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (tuple_in.valid) begin
            item.cmd     <= tuple_in.cmd;
            item.key     <= tuple_in.key;
            item.payload <= tuple_in.payload;
            item.part    <= '0;
            bit_idx      <= KEY_IDX_W'(KEY_W - 1);
            state        <= (tuple_in.cmd == CMD_CLEAR) ? F_PUSH : F_DIV;
          end
        end
        F_DIV: begin
          item.part <= rem_next;
          bit_idx   <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: src/hps_queue.sv
// small fifo of classified items between front and back
module hps_queue import hps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  q_item_t push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output q_item_t pop_item
);

  q_item_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   fill;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (fill != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: src/hps_back.sv
// back end: fill counter memory, slot and address computation, result register
module hps_back import hps_pkg::*; #(
  parameter int MAX_PARTITIONS = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  hps_cfg_t cfg,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  q_item_t  pop_item,
  hps_out_if.source result_out
);

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

  typedef enum logic [1:0] {B_CLR, B_IDLE, B_CALC, B_OUT} b_state_t;

  logic [FILL_W-1:0] mem [MAX_PARTITIONS];
  logic [FILL_W-1:0] rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [FILL_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  b_state_t          state;
  logic [IDX_W-1:0]  clr_idx;
  q_item_t           cur;
  logic              full;
  logic              ovf;
  logic [SLOT_W-1:0] slot;
  logic [PROD_W-1:0] prod;
  logic              out_valid;
  logic              out_load;

  assign full      = (cfg.capacity <= rd_data);
  assign pop_ready = (state == B_IDLE);
  assign mem_raddr = IDX_W'(pop_item.part);
  assign mem_we    = (state == B_CLR) || ((state == B_CALC) && !full);
  assign mem_waddr = (state == B_CLR) ? clr_idx : IDX_W'(cur.part);
  assign mem_wdata = (state == B_CLR) ? '0 : rd_data + 1'b1;

  // result register takes a new beat once the old one is gone or leaving
  assign out_load  = (state == B_OUT) && (!out_valid || result_out.ready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  assign result_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(MAX_PARTITIONS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_valid) begin
            cur <= pop_item;
            if (pop_item.cmd == CMD_CLEAR) begin
              clr_idx <= '0;
              state   <= B_CLR;
            end else begin
              state <= B_CALC;
            end
          end
        end
        B_CALC: begin
          ovf   <= full;
          slot  <= full ? '0 : rd_data[SLOT_W-1:0];
          prod  <= PROD_W'(cur.part) * PROD_W'(cfg.capacity);
          state <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            result_out.partition   <= cur.part[PART_W-1:0];
            result_out.slot        <= slot;
            result_out.address     <= ovf ? '0 : prod[ADDR_W-1:0] + ADDR_W'(slot);
            result_out.key_out     <= cur.key;
            result_out.payload_out <= cur.payload;
            result_out.overflow    <= ovf;
            state                  <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: src/hash_partition_scatter.sv
// top level of the hash partition scatter block
// Each tuple beat on tuple_in (cmd = 0) is sent to partition key mod the partition count
// and given the next slot of that partition's fill counter; the result beat carries
// partition, slot, flat address (partition * capacity + slot), key, payload and an
// overflow flag that is set, with slot and address zero and the counter held, when the
// partition is already full. A clear beat (cmd = 1) zeroes every counter and gives no
// result. The front end's bit-serial remainder unit retires one key bit per cycle and
// the front accepts a new tuple only after the previous one is pushed; the back end
// handles one item at a time and overlaps with the front through a 2-entry queue. A
// clear sweeps the counter memory one entry per cycle; the same clearing pass runs
// after reset, during which the front keeps accepting tuples until the queue is full.
// The user must make configuration writes only while the block is idle; the block
// itself does not enforce this.
module hash_partition_scatter import hps_pkg::*; #(
  parameter int MAX_PARTITIONS = 1024,
  parameter int MAX_CAPACITY   = 1048576
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  hps_in_if.sink               tuple_in,
  hps_out_if.source            result_out
);

  // raw register values as written
  logic [CNT_REG_W-1:0] num_parts;
  logic [CAP_REG_W-1:0] partition_capacity;
  hps_cfg_t             cfg;

  // front to queue and queue to back handshakes
  logic    push_valid;
  logic    push_ready;
  q_item_t push_item;
  logic    pop_valid;
  logic    pop_ready;
  q_item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_parts          <= CNT_REG_W'(1);
      partition_capacity <= CAP_REG_W'(1048576);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PARTITION_COUNT:    num_parts          <= cfg_data[CNT_REG_W-1:0];
        REG_PARTITION_CAPACITY: partition_capacity <= cfg_data[CAP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, values above the build limits clamp to the limit
  always_comb begin
    if (num_parts == '0) begin
      cfg.count = CNT_REG_W'(1);
    end else if (32'(num_parts) > 32'(MAX_PARTITIONS)) begin
      cfg.count = CNT_REG_W'(MAX_PARTITIONS);
    end else begin
      cfg.count = num_parts;
    end
    if (partition_capacity == '0) begin
      cfg.capacity = CAP_REG_W'(1);
    end else if (32'(partition_capacity) > 32'(MAX_CAPACITY)) begin
      cfg.capacity = CAP_REG_W'(MAX_CAPACITY);
    end else begin
      cfg.capacity = partition_capacity;
    end
  end

  // remainder front end
  hps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tuple_in   (tuple_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples remainder unit from counter update
  hps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // counter memory and result register
  hps_back #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .result_out (result_out)
  );

endmodule
